// ===== hdl/ctli_pkg.sv =====
package ctli_pkg;

    localparam int TableDepth = 256;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CountW     = $clog2(TableDepth + 1);
    localparam int ValW       = 18;
    localparam int ProdW      = 2 * ValW;
    localparam int StepW      = $clog2(ValW);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_INV   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [ValW-1:0] position;
        logic signed [ValW-1:0] level;
    } entry_t;

    typedef struct packed {
        logic signed [ValW-1:0] value;
        logic                   clamped;
    } result_t;

endpackage

// ===== hdl/ctli_table.sv =====
module ctli_table (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ctli_pkg::AddrW-1:0] wr_addr,
    input  ctli_pkg::entry_t           wr_data,
    input  logic [ctli_pkg::AddrW-1:0] rd_addr,
    output ctli_pkg::entry_t           rd_data
);
    import ctli_pkg::*;

    entry_t mem [TableDepth];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ctli_divider.sv =====
module ctli_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ctli_pkg::ProdW-1:0] dividend,
    input  logic [ctli_pkg::ValW-1:0]  divisor,
    output logic                       busy,
    output logic [ctli_pkg::ValW-1:0]  quotient
);
    import ctli_pkg::*;

    // Quotient is known to fit in ValW bits, so the top half seeds the remainder.
    logic                busy_reg;
    logic                busy_next;
    logic [StepW-1:0]    cnt_reg;
    logic [StepW-1:0]    cnt_next;
    logic [ValW-1:0]     rem_reg;
    logic [ValW-1:0]     rem_next;
    logic [ValW-1:0]     low_reg;
    logic [ValW-1:0]     low_next;
    logic [ValW:0]       shifted;
    logic [ValW:0]       diff;
    logic                fits;

    assign shifted = {rem_reg, low_reg[ValW-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[ProdW-1:ValW];
            low_next  = dividend[ValW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[ValW-1:0] : shifted[ValW-1:0];
            low_next = {low_reg[ValW-2:0], fits};
            cnt_next = cnt_reg + StepW'(1);
            if (cnt_reg == StepW'(ValW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign busy     = busy_reg;
    assign quotient = low_reg;

endmodule

// ===== hdl/ctli_core.sv =====
module ctli_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        inverse,
    input  logic signed [ctli_pkg::ValW-1:0] query,
    input  logic [ctli_pkg::CountW-1:0] count,
    input  logic                        wr_en,
    input  logic [ctli_pkg::AddrW-1:0]  wr_addr,
    input  ctli_pkg::entry_t            wr_data,
    input  logic                        take,
    output logic                        idle,
    output logic                        done,
    output ctli_pkg::result_t           result
);
    import ctli_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;

    logic                    inv_reg;
    logic signed [ValW-1:0]  q_reg;
    logic [AddrW-1:0]        last_reg;
    logic [AddrW-1:0]        idx_reg;
    logic signed [ValW-1:0]  prev_key_reg;
    logic signed [ValW-1:0]  prev_val_reg;
    logic signed [ValW:0]    den_reg;
    logic [ValW-1:0]         dq_reg;
    logic signed [ValW:0]    db_reg;
    logic signed [ValW-1:0]  b1_reg;
    logic [ProdW-1:0]        prod_reg;
    logic                    neg_reg;
    result_t                 res_reg;

    logic [CountW-1:0]       count_eff;
    logic [AddrW-1:0]        rd_addr;
    entry_t                  rd_data;
    logic signed [ValW-1:0]  cur_key;
    logic signed [ValW-1:0]  cur_val;
    logic                    hit;
    logic                    seg_last;
    logic                    den_pos;
    logic [ValW:0]           db_abs;
    logic                    div_start;
    logic                    div_busy;
    logic [ValW-1:0]         quot;
    logic signed [ValW+1:0]  sum;
    logic signed [ValW-1:0]  sum_sat;

    ctli_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ctli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg[ValW-1:0]),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign count_eff = (count > CountW'(TableDepth)) ? CountW'(TableDepth) : count;

    assign cur_key  = inv_reg ? rd_data.level : rd_data.position;
    assign cur_val  = inv_reg ? rd_data.position : rd_data.level;
    assign hit      = (q_reg >= prev_key_reg) && (q_reg <= cur_key);
    assign seg_last = ({1'b0, idx_reg} + (AddrW + 1)'(1)) == {1'b0, last_reg};
    assign den_pos  = !den_reg[ValW] && (den_reg != '0);
    assign db_abs   = db_reg[ValW] ? (ValW + 1)'(-db_reg) : db_reg;

    // Apply the sign of the level step to the quotient, then saturate.
    assign sum = neg_reg ? ((ValW + 2)'(b1_reg) - (ValW + 2)'({2'b00, quot}))
                         : ((ValW + 2)'(b1_reg) + (ValW + 2)'({2'b00, quot}));

    always_comb
    begin
        if (sum > (ValW + 2)'(2 ** (ValW - 1) - 1))
        begin
            sum_sat = {1'b0, {(ValW - 1){1'b1}}};
        end
        else if (sum < -(ValW + 2)'(2 ** (ValW - 1)))
        begin
            sum_sat = {1'b1, {(ValW - 1){1'b0}}};
        end
        else
        begin
            sum_sat = sum[ValW-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (count_eff == '0) ? ST_DONE : ST_FIRST;
                end
            end
            ST_FIRST:  state_next = (q_reg <= cur_key) ? ST_DONE : ST_LAST;
            ST_LAST:   state_next = (q_reg >= cur_key) ? ST_DONE : ST_SCAN;
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_MUL;
                end
                else if (seg_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:    state_next = den_pos ? ST_DSTART : ST_DONE;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    state_next = div_busy ? ST_DIV : ST_FIN;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE:   state_next = take ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and read address.
    always_comb
    begin
        idle      = 1'b0;
        done      = 1'b0;
        div_start = 1'b0;
        rd_addr   = '0;
        unique case (state_reg)
            ST_IDLE:   idle = 1'b1;
            ST_FIRST:  rd_addr = last_reg;
            ST_LAST:   rd_addr = AddrW'(1);
            ST_SCAN:   rd_addr = idx_reg + AddrW'(2);
            ST_DSTART: div_start = 1'b1;
            ST_DONE:   done = 1'b1;
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                inv_reg  <= inverse;
                q_reg    <= query;
                last_reg <= AddrW'(count_eff - CountW'(1));
                res_reg  <= '{value: query, clamped: 1'b0};
            end
            ST_FIRST, ST_LAST:
            begin
                res_reg <= '{value: cur_val, clamped: 1'b1};
                if (state_reg == ST_FIRST)
                begin
                    prev_key_reg <= cur_key;
                    prev_val_reg <= cur_val;
                end
                idx_reg <= '0;
            end
            ST_SCAN:
            begin
                den_reg <= (ValW + 1)'(cur_key) - (ValW + 1)'(prev_key_reg);
                dq_reg  <= ValW'((ValW + 1)'(q_reg) - (ValW + 1)'(prev_key_reg));
                db_reg  <= (ValW + 1)'(cur_val) - (ValW + 1)'(prev_val_reg);
                b1_reg  <= prev_val_reg;
                res_reg <= '{value: '0, clamped: 1'b0};
                if (!hit)
                begin
                    prev_key_reg <= cur_key;
                    prev_val_reg <= cur_val;
                    idx_reg      <= idx_reg + AddrW'(1);
                end
            end
            ST_MUL:
            begin
                // Zero-extend both factors so the full product is kept.
                prod_reg <= ProdW'(db_abs[ValW-1:0]) * ProdW'(dq_reg);
                neg_reg  <= db_reg[ValW];
                res_reg  <= '{value: b1_reg, clamped: 1'b0};
            end
            ST_FIN:
            begin
                res_reg <= '{value: sum_sat, clamped: 1'b0};
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign result = res_reg;

endmodule

// ===== hdl/curve_table_linear_interp.sv =====
// Piecewise-linear tone-curve table with forward and inverse lookup.
// Requests arrive on req_valid/req_ready; mode selects an entry write, a
// forward lookup (position to level) or an inverse lookup (level to position).
// Each lookup yields one response on res_valid/res_ready; writes and mode 3
// yield none. cfg_we/cfg_data set entries_in_use; write it only while idle.
// A write goes straight into the table memory. A lookup with no entries in
// use, or one that clamps at either table end, ends without a segment walk.
// An interior lookup walks the segments one per cycle, then runs the
// multiply and the bit-serial divider, so its time grows with the segment
// it lands in, up to the last one of a full 256-entry table. The single
// read port of the table memory and the serial divider set that pace.
// One request is in flight at a time; req_ready is high only when the
// sequencer is idle.
// Reset clears entries_in_use and all control state; the table contents stay
// undefined until written. A finished response sits in the output register,
// and the next request is taken while it waits; a later response holds in the
// sequencer until the receiver drains the register.
module curve_table_linear_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ctli_pkg::CountW-1:0]       cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        mode,
    input  logic [ctli_pkg::AddrW-1:0]        entry_index,
    input  logic signed [ctli_pkg::ValW-1:0]  entry_position,
    input  logic signed [ctli_pkg::ValW-1:0]  entry_level,
    input  logic signed [ctli_pkg::ValW-1:0]  query_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic signed [ctli_pkg::ValW-1:0]  result_value,
    output logic                              was_clamped
);
    import ctli_pkg::*;

    logic [CountW-1:0]       count_reg;
    logic [CountW-1:0]       count_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    result_t                 res_data_reg;

    logic                    core_idle;
    logic                    core_done;
    result_t                 core_result;
    logic                    req_fire;
    logic                    wr_en;
    logic                    start;
    logic                    take;
    entry_t                  wr_data;

    // Advance a request only while the sequencer is idle.
    assign req_ready = core_idle;
    assign req_fire  = req_valid && req_ready;
    assign wr_en     = req_fire && (mode == MODE_WRITE);
    assign start     = req_fire && ((mode == MODE_FWD) || (mode == MODE_INV));
    assign wr_data   = '{position: entry_position, level: entry_level};

    // Hold the finished response in the sequencer until the output register frees up.
    assign take = core_done && (!res_valid_reg || res_ready);

    ctli_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .inverse (mode == MODE_INV),
        .query   (query_value),
        .count   (count_reg),
        .wr_en   (wr_en),
        .wr_addr (entry_index),
        .wr_data (wr_data),
        .take    (take),
        .idle    (core_idle),
        .done    (core_done),
        .result  (core_result)
    );

    assign count_next = cfg_we ? cfg_data : count_reg;

    always_comb
    begin
        priority if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_data_reg <= core_result;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_value = res_data_reg.value;
    assign was_clamped  = res_data_reg.clamped;

endmodule
